// ===== rtl/srpg_pkg.sv =====
// Shared types and constants for the stepper ramp pulse generator.
`timescale 1ns / 1ps

package srpg_pkg;

	localparam int COUNT_BITS  = 16;
	localparam int DELAY_BITS  = 16;
	localparam int CDLY_BITS   = DELAY_BITS + 1;
	localparam int ACCEL_BITS  = 16;
	localparam int PULSE_TICKS = 10;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	localparam logic [1:0] REG_MAX_DELAY = 2'd0;
	localparam logic [1:0] REG_MIN_DELAY = 2'd1;
	localparam logic [1:0] REG_ACCEL     = 2'd2;
	localparam logic [1:0] REG_DIR_POL   = 2'd3;

	typedef struct packed {
		logic [DELAY_BITS-1:0] max_delay;
		logic [DELAY_BITS-1:0] min_delay;
		logic [ACCEL_BITS-1:0] accel_steps;
		logic                  dir_pol;
	} cfg_t;

	typedef struct packed {
		logic                  action;
		logic [COUNT_BITS-1:0] move_steps;
		logic                  forward;
	} item_t;

	typedef struct packed {
		logic exec;
		logic load_inc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic idle;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/srpg_cfg.sv =====
// APB register file holding the ramp configuration.
`timescale 1ns / 1ps

module srpg_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output srpg_pkg::cfg_t    cfg
);

	srpg_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_delay   <= srpg_pkg::DELAY_BITS'(2000);
			cfg_q.min_delay   <= srpg_pkg::DELAY_BITS'(500);
			cfg_q.accel_steps <= srpg_pkg::ACCEL_BITS'(200);
			cfg_q.dir_pol     <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				srpg_pkg::REG_MAX_DELAY: cfg_q.max_delay <= pwdata[srpg_pkg::DELAY_BITS-1:0];
				srpg_pkg::REG_MIN_DELAY: cfg_q.min_delay <= pwdata[srpg_pkg::DELAY_BITS-1:0];
				srpg_pkg::REG_ACCEL: cfg_q.accel_steps <= pwdata[srpg_pkg::ACCEL_BITS-1:0];
				srpg_pkg::REG_DIR_POL: cfg_q.dir_pol <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			srpg_pkg::REG_MAX_DELAY: prdata = 32'(cfg_q.max_delay);
			srpg_pkg::REG_MIN_DELAY: prdata = 32'(cfg_q.min_delay);
			srpg_pkg::REG_ACCEL: prdata = 32'(cfg_q.accel_steps);
			srpg_pkg::REG_DIR_POL: prdata = 32'(cfg_q.dir_pol);
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/srpg_div.sv =====
// Serial restoring divider for the ramp increment, one quotient bit per cycle.
`timescale 1ns / 1ps

module srpg_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [srpg_pkg::DELAY_BITS-1:0]        max_delay,
	input  logic [srpg_pkg::DELAY_BITS-1:0]        min_delay,
	input  logic [srpg_pkg::ACCEL_BITS-1:0]        accel_steps,
	output logic                                   done,
	output logic signed [srpg_pkg::CDLY_BITS-1:0]  quotient
);

	localparam int QW = srpg_pkg::DELAY_BITS;
	localparam int DW = srpg_pkg::ACCEL_BITS;
	localparam int CW = $clog2(QW);

	logic [QW-1:0]         quo_q;
	logic [DW:0]           rem_q;
	logic [DW-1:0]         dvs_q;
	logic                  neg_q;
	logic                  zero_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic signed [QW:0]    diff;
	logic [QW-1:0]         mag;
	logic [DW:0]           rem_sh;
	logic [DW:0]           rem_sub;
	logic                  fits;
	logic [QW:0]           quo_ext;

	assign diff = signed'({1'b0, max_delay}) - signed'({1'b0, min_delay});
	assign mag  = diff[QW] ? QW'(-diff) : diff[QW-1:0];

	assign rem_sh  = {rem_q[DW-1:0], quo_q[QW-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= mag;
			rem_q  <= '0;
			dvs_q  <= accel_steps;
			neg_q  <= diff[QW];
			zero_q <= (accel_steps == '0);
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub : rem_sh;
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign quo_ext  = zero_q ? '0 : {1'b0, quo_q};
	assign quotient = neg_q ? -signed'(quo_ext) : signed'(quo_ext);
	assign done     = done_q;

endmodule

// ===== rtl/srpg_dp.sv =====
// Ramp datapath: pulse phase counters, delay ramp and the result register.
`timescale 1ns / 1ps

module srpg_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  srpg_pkg::cmd_t                         cmd,
	output srpg_pkg::sts_t                         sts,
	input  srpg_pkg::item_t                        item,
	input  srpg_pkg::cfg_t                         cfg,
	input  logic signed [srpg_pkg::CDLY_BITS-1:0]  quotient,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [7:0]                             m_tdata
);

	localparam int CB = srpg_pkg::COUNT_BITS;
	localparam int LB = srpg_pkg::CDLY_BITS;
	localparam int SW = LB + 2;
	localparam int TW = CB + 2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	logic [1:0]           phase_q;
	logic [LB-1:0]        cnt_q;
	logic [CB-1:0]        idx_q;
	logic [CB-1:0]        total_q;
	logic [LB-1:0]        cur_q;
	logic signed [LB-1:0] inc_q;
	logic                 dir_q;
	logic                 done_q;
	logic                 out_valid_q;
	logic [7:0]           out_data_q;

	logic [LB-1:0]        cnt_inc;
	logic [CB-1:0]        idx_inc;
	logic signed [SW-1:0] d_base;
	logic signed [SW-1:0] d_sum;
	logic signed [SW-1:0] d_min;
	logic [LB-1:0]        d_next;
	logic signed [TW-1:0] thresh;
	logic                 in_accel;
	logic                 in_decel;

	assign cnt_inc = cnt_q + 1'b1;
	assign idx_inc = idx_q + 1'b1;

	assign d_base   = signed'(SW'(cur_q));
	assign thresh   = signed'(TW'(total_q)) - signed'(TW'(cfg.accel_steps));
	assign in_accel = TW'(idx_q) < TW'(cfg.accel_steps);
	assign in_decel = signed'(TW'(idx_q)) > thresh;
	assign d_min    = signed'(SW'(cfg.min_delay));

	always_comb begin
		d_sum = d_base;
		if (in_accel) begin
			d_sum = d_base - SW'(inc_q);
		end else if (in_decel) begin
			d_sum = d_base + SW'(inc_q);
		end
		if (d_sum < d_min) begin
			d_next = LB'(cfg.min_delay);
		end else if (d_sum > signed'(SW'({LB{1'b1}}))) begin
			d_next = {LB{1'b1}};
		end else begin
			d_next = d_sum[LB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			total_q     <= '0;
			cur_q       <= '0;
			inc_q       <= '0;
			dir_q       <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				done_q <= 1'b0;
				if (item.action == srpg_pkg::ACT_START) begin
					if (phase_q == PH_IDLE) begin
						dir_q   <= (item.forward == cfg.dir_pol);
						total_q <= item.move_steps;
						idx_q   <= '0;
						cnt_q   <= '0;
						cur_q   <= LB'(cfg.max_delay);
						if (item.move_steps == '0) begin
							done_q <= 1'b1;
						end else begin
							phase_q <= PH_HIGH;
						end
					end
				end else begin
					case (phase_q)
						PH_HIGH: begin
							if (cnt_inc >= LB'(srpg_pkg::PULSE_TICKS)) begin
								phase_q <= PH_LOW;
								cnt_q   <= '0;
							end else begin
								cnt_q <= cnt_inc;
							end
						end
						PH_LOW: begin
							if (cnt_inc >= cur_q) begin
								cnt_q <= '0;
								cur_q <= d_next;
								idx_q <= idx_inc;
								if (idx_inc >= total_q) begin
									phase_q <= PH_IDLE;
									done_q  <= 1'b1;
								end else begin
									phase_q <= PH_HIGH;
								end
							end else begin
								cnt_q <= cnt_inc;
							end
						end
						default: ;
					endcase
				end
			end
			if (cmd.load_inc) begin
				inc_q <= quotient;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {4'b0000, done_q, (phase_q != PH_IDLE), dir_q, (phase_q == PH_HIGH)};
		end
	end

	assign sts.idle     = (phase_q == PH_IDLE);
	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;

endmodule

// ===== rtl/srpg_ctrl.sv =====
// Sequencer for item intake, execution, increment divide and result hand-off.
`timescale 1ns / 1ps

module srpg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            item_action,
	input  srpg_pkg::sts_t  sts,
	output srpg_pkg::cmd_t  cmd,
	output logic            div_start,
	input  logic            div_done
);

	localparam logic [1:0] ST_READY = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		div_start = 1'b0;
		s_tready  = 1'b0;
		case (state_q)
			ST_READY: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (item_action == srpg_pkg::ACT_START && sts.idle) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					cmd.load_inc = 1'b1;
					state_d      = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_READY;
				end
			end
			default: state_d = ST_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/stepper_ramp_pulse_generator.sv =====
// Top level of the stepper ramp pulse generator.
// A tick item (or a start on a busy generator) passes through the execute and output states
// after acceptance; the next item can be accepted once its result is in the output register.
// A start item on an idle generator also waits in the divide state for the 16-step serial
// divider before its result is loaded. Output stalls delay both the result and the next item.
// The next item is accepted while a finished result still waits on the output register.
// Reset (arst_n low, asynchronous) idles the generator and loads the default ramp registers.
`timescale 1ns / 1ps

module stepper_ramp_pulse_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // move_steps[15:0], forward[16], zero fill
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // step_level, dir_level, busy_res, move_done, zero fill
);

	srpg_pkg::cfg_t  cfg;
	srpg_pkg::cmd_t  cmd;
	srpg_pkg::sts_t  sts;
	srpg_pkg::item_t item_q;
	logic            div_start;
	logic            div_done;
	logic signed [srpg_pkg::CDLY_BITS-1:0] quotient;

	assign pready = 1'b1;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q.action     <= s_tuser;
			item_q.move_steps <= s_tdata[srpg_pkg::COUNT_BITS-1:0];
			item_q.forward    <= s_tdata[srpg_pkg::COUNT_BITS];
		end
	end

	srpg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	srpg_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.max_delay   (cfg.max_delay),
		.min_delay   (cfg.min_delay),
		.accel_steps (cfg.accel_steps),
		.done        (div_done),
		.quotient    (quotient)
	);

	srpg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.item_action (item_q.action),
		.sts         (sts),
		.cmd         (cmd),
		.div_start   (div_start),
		.div_done    (div_done)
	);

	srpg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item_q),
		.cfg      (cfg),
		.quotient (quotient),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== dv/stepper_ramp_pulse_generator_test.sv =====
// Self-checking testbench for the stepper ramp pulse generator.
`timescale 1ns / 1ps

module stepper_ramp_pulse_generator_test;
	import srpg_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DLY_CEIL    = (1 << CDLY_BITS) - 1;

	typedef enum logic [1:0] {MV_IDLE, MV_HIGH, MV_LOW} move_phase_e;

	// m_tdata[3:0] from the lowest bit up: step, dir, busy, done
	typedef struct packed {
		logic move_done;
		logic busy;
		logic dir;
		logic step;
	} pulse_levels_t;

	class ramp_scoreboard;
		cfg_t                  cfg;
		move_phase_e           phase;
		logic [CDLY_BITS-1:0]  phase_ticks;
		logic [COUNT_BITS-1:0] pulse_idx;
		logic [COUNT_BITS-1:0] total;
		logic [CDLY_BITS-1:0]  cur_delay;
		logic signed [CDLY_BITS-1:0] ramp_step;
		logic                  dir_q;
		pulse_levels_t         expected_levels[$];
		int                    mismatches;
		int                    checked;
		int                    moves;

		function new();
			cfg.max_delay   = 16'd2000;
			cfg.min_delay   = 16'd500;
			cfg.accel_steps = 16'd200;
			cfg.dir_pol     = 1'b0;
			phase       = MV_IDLE;
			phase_ticks = '0;
			pulse_idx   = '0;
			total       = '0;
			cur_delay   = '0;
			ramp_step   = '0;
			dir_q       = 1'b0;
			mismatches  = 0;
			checked     = 0;
			moves       = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_MAX_DELAY: cfg.max_delay = val[DELAY_BITS-1:0];
				REG_MIN_DELAY: cfg.min_delay = val[DELAY_BITS-1:0];
				REG_ACCEL:     cfg.accel_steps = val[ACCEL_BITS-1:0];
				REG_DIR_POL:   cfg.dir_pol = val[0];
				default: ;
			endcase
		endfunction

		function bit busy();
			return phase != MV_IDLE;
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction

		// next delay at the end of a low phase
		function void close_pulse();
			int d;
			d = int'(cur_delay);
			if (int'(pulse_idx) < int'(cfg.accel_steps))
				d -= int'(ramp_step);
			else if (int'(pulse_idx) > int'(total) - int'(cfg.accel_steps))
				d += int'(ramp_step);
			if (d < int'(cfg.min_delay))
				d = int'(cfg.min_delay);
			if (d > DLY_CEIL)
				d = DLY_CEIL;
			cur_delay = d[CDLY_BITS-1:0];
			pulse_idx = pulse_idx + 1'b1;
		endfunction

		// returns 1 when the item has an effect on the generator
		function bit advance_ramp(logic act, logic [COUNT_BITS-1:0] steps, logic fwd);
			bit effective;
			pulse_levels_t lv;
			int q;
			effective = 1'b1;
			lv = '0;
			if (act == ACT_START) begin
				if (phase == MV_IDLE) begin
					dir_q = (fwd == cfg.dir_pol);
					q = 0;
					if (cfg.accel_steps != 0)
						q = (int'(cfg.max_delay) - int'(cfg.min_delay)) / int'(cfg.accel_steps);
					ramp_step   = q[CDLY_BITS-1:0];
					total       = steps;
					pulse_idx   = '0;
					phase_ticks = '0;
					cur_delay   = {1'b0, cfg.max_delay};
					moves++;
					if (steps == 0)
						lv.move_done = 1'b1;
					else
						phase = MV_HIGH;
				end else begin
					effective = 1'b0;
				end
			end else if (phase == MV_HIGH) begin
				phase_ticks = phase_ticks + 1'b1;
				if (phase_ticks >= PULSE_TICKS) begin
					phase = MV_LOW;
					phase_ticks = '0;
				end
			end else if (phase == MV_LOW) begin
				phase_ticks = phase_ticks + 1'b1;
				if (phase_ticks >= cur_delay) begin
					phase_ticks = '0;
					close_pulse();
					if (pulse_idx >= total) begin
						phase = MV_IDLE;
						lv.move_done = 1'b1;
					end else begin
						phase = MV_HIGH;
					end
				end
			end else begin
				effective = 1'b0;
			end
			lv.step = (phase == MV_HIGH);
			lv.dir  = dir_q;
			lv.busy = (phase != MV_IDLE);
			expected_levels.push_back(lv);
			return effective;
		endfunction

		function void note_mismatch(string what, logic [7:0] want, logic [7:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s, expected %02h got %02h", $time, what, want, got);
		endfunction

		function void check_levels(logic [7:0] data);
			pulse_levels_t want;
			pulse_levels_t got;
			got = data[3:0];
			checked++;
			if (expected_levels.size() == 0) begin
				note_mismatch("unexpected result", 8'h00, data);
				return;
			end
			want = expected_levels.pop_front();
			if (got.step !== want.step || got.dir !== want.dir || got.busy !== want.busy
					|| got.move_done !== want.move_done || data[7:4] !== 4'h0)
				note_mismatch($sformatf("result %0d", checked), {4'h0, want}, data);
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	ramp_scoreboard sb = new();
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int items_sent   = 0;
	int items_live   = 0;
	int reg_writes   = 0;
	int cycle_count  = 0;

	stepper_ramp_pulse_generator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= dst_idle_pct);
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_levels(m_tdata);
		end
	end

	task automatic send_item(input logic act, input logic [15:0] steps, input logic fwd);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'b0, fwd, steps};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (sb.advance_ramp(act, steps, fwd))
			items_live++;
	endtask

	task automatic send_tick();
		send_item(ACT_TICK, 16'($urandom), 1'($urandom));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(idx, val);
		reg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic new_settings();
		int r;
		r = $urandom_range(9);
		write_reg(REG_MAX_DELAY, (r == 0) ? 0 : (r == 1) ? $urandom_range(0, 3)
			: $urandom_range(0, 20));
		write_reg(REG_MIN_DELAY, ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 15));
		r = $urandom_range(9);
		write_reg(REG_ACCEL, (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 65535)
			: $urandom_range(1, 5));
		write_reg(REG_DIR_POL, $urandom_range(1));
	endtask

	// one move: optional reconfiguration, optional leading ticks, start, ticks with stray starts, sometimes cut short
	task automatic run_move();
		int r;
		int stop_after;
		bit cut_short;
		if ($urandom_range(99) < 40) begin
			wait_drain();
			new_settings();
		end
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 3)) send_tick();
		r = $urandom_range(9);
		send_item(ACT_START, (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom_range(6, 12))
			: 16'($urandom_range(1, 5)), 1'($urandom));
		cut_short  = ($urandom_range(9) == 0);
		stop_after = $urandom_range(1, 30);
		while (sb.busy() && !(cut_short && stop_after == 0)) begin
			if ($urandom_range(99) < 6)
				send_item(ACT_START, 16'($urandom), 1'($urandom));
			else
				send_tick();
			stop_after--;
		end
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int n);
		int first;
		src_idle_pct = tx_pct;
		dst_idle_pct = rx_pct;
		first = items_live;
		while (items_live - first < n)
			run_move();
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// idle tick, zero-step starts in both directions
		send_item(ACT_TICK, 16'hFFFF, 1'b1);
		send_item(ACT_START, 16'd0, 1'b0);
		send_item(ACT_START, 16'd0, 1'b1);
		wait_drain();
		// zero delays and zero ramp length
		write_reg(REG_MAX_DELAY, 0);
		write_reg(REG_MIN_DELAY, 0);
		write_reg(REG_ACCEL, 0);
		write_reg(REG_DIR_POL, 1);
		send_item(ACT_START, 16'd2, 1'b1);
		send_item(ACT_START, 16'hA5A5, 1'b0);
		wait_drain();
		write_reg(REG_MIN_DELAY, 3);
		while (sb.busy())
			send_tick();

		run_phase(23, 63, 110);
		run_phase(63, 23, 110);
		run_phase(0, 0, 110);

		// finish any cut-short move, then the largest settings and count
		while (sb.busy())
			send_tick();
		wait_drain();
		write_reg(REG_MAX_DELAY, 32'hFFFF);
		write_reg(REG_MIN_DELAY, 32'hFFFF);
		write_reg(REG_ACCEL, 32'hFFFF);
		write_reg(REG_DIR_POL, 0);
		send_item(ACT_START, 16'hFFFF, 1'b1);
		repeat (150) send_tick();

		wait_drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d items (%0d took effect) over %0d moves and %0d register writes",
			items_sent, items_live, sb.moves, reg_writes);
		$display("Compared %0d results: %0d mismatches, %0d still expected",
			sb.checked, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/srpg_pkg.sv
rtl/srpg_cfg.sv
rtl/srpg_div.sv
rtl/srpg_dp.sv
rtl/srpg_ctrl.sv
rtl/stepper_ramp_pulse_generator.sv
dv/stepper_ramp_pulse_generator_test.sv
